[hdl/rcst_pkg.sv]
`default_nettype none
package rcst_pkg;

   localparam int SLOT_COUNT_DEF = 4;

   localparam int DEV_W   = 16;
   localparam int BOOT_W  = 16;
   localparam int MSG_W   = 16;
   localparam int TRIES_W = 4;
   localparam int STAT_W  = 3;

   localparam logic [BOOT_W-1:0]  BOOT_NONE    = 16'hFFFF;
   localparam logic [TRIES_W-1:0] BUDGET_RESET = 4'd4;

   localparam logic ACT_QUEUE = 1'b0;
   localparam logic ACT_TAKE  = 1'b1;

   localparam logic [STAT_W-1:0] STAT_QUEUED    = 3'd0;
   localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
   localparam logic [STAT_W-1:0] STAT_DELIVERED = 3'd2;
   localparam logic [STAT_W-1:0] STAT_NONE      = 3'd3;
   localparam logic [STAT_W-1:0] STAT_REBOOTED  = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the accepted request
      logic lookup;    // register the slot search results
      logic apply;     // update the table and load the response register
   } cmd_type;

endpackage
`default_nettype wire

[hdl/rcst_ctrl.sv]
`default_nettype none
module rcst_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      rcst_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LOOK  = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.lookup  = 1'b0;
      cmd.apply   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cmd.lookup = 1'b1;
            state_in   = ST_APPLY;
         end
         ST_APPLY: begin
            if (out_free) begin
               cmd.apply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.apply) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The response register is never overwritten while it still holds an untaken response.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten");

   // An accepted request is always followed by the lookup cycle.
   a_accept_then_look: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> cmd.lookup)
      else $error("lookup did not follow accept");

   // Finishing an operation always presents a response on the next cycle.
   a_apply_then_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> rsp_valid)
      else $error("response missing after apply");

   // At most one command is issued per cycle.
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.lookup, cmd.apply}))
      else $error("overlapping commands");

endmodule
`default_nettype wire

[hdl/rcst_datapath.sv]
`default_nettype none
module rcst_datapath #(
   parameter int SLOT_COUNT = rcst_pkg::SLOT_COUNT_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire rcst_pkg::cmd_type            cmd,
   input  wire logic                         csr_wr_en,
   input  wire logic [rcst_pkg::TRIES_W-1:0] csr_wr_data,
   input  wire logic                         req_action,
   input  wire logic [rcst_pkg::DEV_W-1:0]   req_device_id,
   input  wire logic [rcst_pkg::BOOT_W-1:0]  req_boot_count,
   input  wire logic [rcst_pkg::MSG_W-1:0]   req_message_handle,
   output      logic [rcst_pkg::STAT_W-1:0]  rsp_status,
   output      logic [rcst_pkg::MSG_W-1:0]   rsp_message_out,
   output      logic [rcst_pkg::TRIES_W-1:0] rsp_tries_remaining
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // Configuration.
   logic [rcst_pkg::TRIES_W-1:0] budget_ff;

   // Slot table; only the active bits need a reset.
   logic [SLOT_COUNT-1:0]        slot_active_ff;
   logic [rcst_pkg::DEV_W-1:0]   slot_device_ff     [SLOT_COUNT];
   logic [rcst_pkg::MSG_W-1:0]   slot_message_ff    [SLOT_COUNT];
   logic [rcst_pkg::TRIES_W-1:0] slot_tries_ff      [SLOT_COUNT];
   logic [rcst_pkg::BOOT_W-1:0]  slot_boot_start_ff [SLOT_COUNT];

   // Captured request.
   logic                         cap_action_ff;
   logic [rcst_pkg::DEV_W-1:0]   cap_device_ff;
   logic [rcst_pkg::BOOT_W-1:0]  cap_boot_ff;
   logic [rcst_pkg::MSG_W-1:0]   cap_message_ff;

   // Search results.
   logic             hit_found_ff, hit_found_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;

   // Response register.
   logic [rcst_pkg::STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [rcst_pkg::MSG_W-1:0]   rsp_message_ff, rsp_message_in;
   logic [rcst_pkg::TRIES_W-1:0] rsp_tries_ff, rsp_tries_in;

   // Update of the selected slot.
   logic [IDX_W-1:0]             sel;
   logic                         wr_en;
   logic                         new_active;
   logic [rcst_pkg::MSG_W-1:0]   new_message;
   logic [rcst_pkg::TRIES_W-1:0] new_tries;
   logic [rcst_pkg::BOOT_W-1:0]  new_boot;
   logic [rcst_pkg::MSG_W-1:0]   rd_message;
   logic [rcst_pkg::TRIES_W-1:0] rd_tries;
   logic [rcst_pkg::BOOT_W-1:0]  rd_boot;
   logic [rcst_pkg::TRIES_W-1:0] dec_tries;

   assign rsp_status          = rsp_status_ff;
   assign rsp_message_out     = rsp_message_ff;
   assign rsp_tries_remaining = rsp_tries_ff;

   // Lowest-numbered match wins: scan downward so the lowest index is written last.
   always_comb begin
      hit_found_in  = 1'b0;
      hit_idx_in    = '0;
      free_found_in = 1'b0;
      free_idx_in   = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (slot_active_ff[i] && (slot_device_ff[i] == cap_device_ff)) begin
            hit_found_in = 1'b1;
            hit_idx_in   = IDX_W'(i);
         end
         if (!slot_active_ff[i]) begin
            free_found_in = 1'b1;
            free_idx_in   = IDX_W'(i);
         end
      end
   end

   assign sel = ((cap_action_ff == rcst_pkg::ACT_QUEUE) && !hit_found_ff) ?
                free_idx_ff : hit_idx_ff;

   assign rd_message = slot_message_ff[sel];
   assign rd_tries   = slot_tries_ff[sel];
   assign rd_boot    = slot_boot_start_ff[sel];
   assign dec_tries  = (rd_tries != '0) ? (rd_tries - 1'b1) : '0;

   always_comb begin
      wr_en          = 1'b0;
      new_active     = 1'b0;
      new_message    = rd_message;
      new_tries      = rd_tries;
      new_boot       = rd_boot;
      rsp_status_in  = rcst_pkg::STAT_NONE;
      rsp_message_in = '0;
      rsp_tries_in   = '0;
      if (cap_action_ff == rcst_pkg::ACT_QUEUE) begin
         if (hit_found_ff || free_found_ff) begin
            wr_en         = 1'b1;
            new_active    = 1'b1;
            new_message   = cap_message_ff;
            new_tries     = budget_ff;
            new_boot      = rcst_pkg::BOOT_NONE;
            rsp_status_in = rcst_pkg::STAT_QUEUED;
            rsp_tries_in  = budget_ff;
         end else begin
            rsp_status_in = rcst_pkg::STAT_FULL;
         end
      end else if (hit_found_ff) begin
         wr_en = 1'b1;
         if ((rd_boot != rcst_pkg::BOOT_NONE) && (cap_boot_ff != rd_boot)) begin
            // Device rebooted since first delivery: drop the command.
            new_active    = 1'b0;
            rsp_status_in = rcst_pkg::STAT_REBOOTED;
         end else begin
            if (rd_boot == rcst_pkg::BOOT_NONE) begin
               new_boot = cap_boot_ff;
            end
            new_tries      = dec_tries;
            new_active     = (dec_tries != '0);
            rsp_status_in  = rcst_pkg::STAT_DELIVERED;
            rsp_message_in = rd_message;
            rsp_tries_in   = dec_tries;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff      <= rcst_pkg::BUDGET_RESET;
         slot_active_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            budget_ff <= csr_wr_data;
         end
         if (cmd.apply && wr_en) begin
            slot_active_ff[sel] <= new_active;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cap_action_ff  <= req_action;
         cap_device_ff  <= req_device_id;
         cap_boot_ff    <= req_boot_count;
         cap_message_ff <= req_message_handle;
      end
      if (cmd.lookup) begin
         hit_found_ff  <= hit_found_in;
         hit_idx_ff    <= hit_idx_in;
         free_found_ff <= free_found_in;
         free_idx_ff   <= free_idx_in;
      end
      if (cmd.apply) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_message_ff <= rsp_message_in;
         rsp_tries_ff   <= rsp_tries_in;
         if (wr_en) begin
            slot_device_ff[sel]     <= cap_device_ff;
            slot_message_ff[sel]    <= new_message;
            slot_tries_ff[sel]      <= new_tries;
            slot_boot_start_ff[sel] <= new_boot;
         end
      end
   end

   // A queued response always reports the budget in force when the slot was filled.
   a_queue_tries: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply && (rsp_status_in == rcst_pkg::STAT_QUEUED)) |=>
         (rsp_tries_ff == $past(budget_ff)))
      else $error("queued tries differ from budget");

   // Only deliveries carry a message handle.
   a_msg_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply && (rsp_status_in != rcst_pkg::STAT_DELIVERED)) |-> (rsp_message_in == '0))
      else $error("message on non-delivery");

   // A take never touches a slot it did not find.
   a_take_hit: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply && wr_en && (cap_action_ff == rcst_pkg::ACT_TAKE)) |-> hit_found_ff)
      else $error("take wrote without a hit");

endmodule
`default_nettype wire

[hdl/retry_command_slot_table_top.sv]
`default_nettype none
// Channel   Direction  Handshake             Payload
// request   in         req_valid/req_ready   req_action, req_device_id, req_boot_count,
//                                            req_message_handle
// response  out        rsp_valid/rsp_ready   rsp_status, rsp_message_out,
//                                            rsp_tries_remaining
// csr       in         csr_wr_en             csr_wr_data (retry budget, 4 bits)
//
// Each request passes through three steps from acceptance to a loaded response: it is
// captured, all slots are searched in parallel, and the chosen slot is updated.
// The controller handles one request at a time, so it accepts no new request until the
// previous one has finished its update step, which holds while the response is untaken.
// A new request is accepted while the previous response still waits in its register;
// the update cycle holds until that register is free.
// Reset is synchronous and active high; it frees every slot and sets the budget to 4.
module retry_command_slot_table_top #(
   parameter int SLOT_COUNT = rcst_pkg::SLOT_COUNT_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic                         req_action,
   input  wire logic [rcst_pkg::DEV_W-1:0]   req_device_id,
   input  wire logic [rcst_pkg::BOOT_W-1:0]  req_boot_count,
   input  wire logic [rcst_pkg::MSG_W-1:0]   req_message_handle,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic [rcst_pkg::STAT_W-1:0]  rsp_status,
   output      logic [rcst_pkg::MSG_W-1:0]   rsp_message_out,
   output      logic [rcst_pkg::TRIES_W-1:0] rsp_tries_remaining,
   input  wire logic                         csr_wr_en,
   input  wire logic [rcst_pkg::TRIES_W-1:0] csr_wr_data
);

   // Command bundle from the sequencer to the slot table datapath.
   rcst_pkg::cmd_type cmd;

   // The controller sequences capture, search and update, and owns the response valid.
   rcst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // The datapath holds the slot table, the retry budget and the response register.
   rcst_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_action          (req_action),
      .req_device_id       (req_device_id),
      .req_boot_count      (req_boot_count),
      .req_message_handle  (req_message_handle),
      .rsp_status          (rsp_status),
      .rsp_message_out     (rsp_message_out),
      .rsp_tries_remaining (rsp_tries_remaining)
   );

endmodule
`default_nettype wire
